>>> hw/rtl/skf_pkg.sv
package skf_pkg;

    // fraction bits of all fixed-point values
    localparam int FRAC_BITS_DEF = 16;

    // configuration port
    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;

    // register index, taken from paddr[2]
    localparam logic REG_PROCESS_NOISE = 1'b0;
    localparam logic REG_MEASURE_NOISE = 1'b1;

    localparam logic [31:0] PROCESS_NOISE_RST = 32'd655;
    localparam logic [31:0] MEASURE_NOISE_RST = 32'd65536;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic pred;
        logic div_init;
        logic div_step;
        logic mul_x;
        logic mul_p;
        logic commit;
    } skf_cmd_t;

endpackage

>>> hw/rtl/skf_if.sv
// measurement channel
interface skf_meas_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] measurement;

    modport source (output valid, output measurement, input ready);
    modport sink   (input valid, input measurement, output ready);
    modport mon    (input valid, input measurement, input ready);
endinterface

// estimate channel
interface skf_est_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] estimate;

    modport source (output valid, output estimate, input ready);
    modport sink   (input valid, input estimate, output ready);
    modport mon    (input valid, input estimate, input ready);
endinterface

>>> hw/rtl/skf_regs.sv
module skf_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [skf_pkg::ADDR_W-1:0]  paddr,
    input  logic [skf_pkg::DATA_W-1:0]  pwdata,
    output logic [skf_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output logic [31:0]                 process_noise,
    output logic [31:0]                 measure_noise
);

    logic [31:0] process_noise_reg;
    logic [31:0] process_noise_next;
    logic [31:0] measure_noise_reg;
    logic [31:0] measure_noise_next;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // write decode
    always_comb
    begin
        process_noise_next = process_noise_reg;
        measure_noise_next = measure_noise_reg;
        if (wr_en)
        begin
            unique case (paddr[2])
                skf_pkg::REG_PROCESS_NOISE: process_noise_next = pwdata;
                skf_pkg::REG_MEASURE_NOISE: measure_noise_next = pwdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            process_noise_reg <= skf_pkg::PROCESS_NOISE_RST;
            measure_noise_reg <= skf_pkg::MEASURE_NOISE_RST;
        end
        else
        begin
            process_noise_reg <= process_noise_next;
            measure_noise_reg <= measure_noise_next;
        end
    end

    // read mux
    always_comb
    begin
        unique case (paddr[2])
            skf_pkg::REG_PROCESS_NOISE: prdata = process_noise_reg;
            skf_pkg::REG_MEASURE_NOISE: prdata = measure_noise_reg;
            default:                    prdata = '0;
        endcase
    end

    assign process_noise = process_noise_reg;
    assign measure_noise = measure_noise_reg;

endmodule

>>> hw/rtl/skf_ctrl.sv
module skf_ctrl #(
    parameter int FRAC_BITS = skf_pkg::FRAC_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output skf_pkg::skf_cmd_t cmd
);

    localparam int CNT_W = $clog2(FRAC_BITS + 2);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PRED  = 3'd1;
    localparam logic [2:0] S_DINIT = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_MULX  = 3'd4;
    localparam logic [2:0] S_MULP  = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;

    logic [2:0]       state_reg;
    logic [2:0]       state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_PRED;
                end
            end
            S_PRED:
            begin
                cmd.pred   = 1'b1;
                state_next = S_DINIT;
            end
            S_DINIT:
            begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == CNT_W'(FRAC_BITS))
                begin
                    state_next = S_MULX;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            S_MULX:
            begin
                cmd.mul_x  = 1'b1;
                state_next = S_MULP;
            end
            S_MULP:
            begin
                cmd.mul_p  = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                // hold until the output register is free
                if (slot_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

>>> hw/rtl/skf_dp.sv
module skf_dp #(
    parameter int FRAC_BITS = skf_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  skf_pkg::skf_cmd_t  cmd,
    input  logic signed [15:0] measurement,
    input  logic [31:0]        process_noise,
    input  logic [31:0]        measure_noise,
    output logic signed [31:0] estimate
);

    localparam int GW = FRAC_BITS + 1;          // gain, 0 .. 2^F inclusive
    localparam int PW = 34 + FRAC_BITS + 2;     // product width
    localparam int MW = 17 + FRAC_BITS;         // scaled measurement
    localparam int CW = (MW > 33) ? MW : 33;
    localparam int SW = 37;                     // estimate update sum

    localparam logic [GW-1:0]        ONE    = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic signed [CW-1:0] M_MAX  = CW'(64'sd2147483647);
    localparam logic signed [CW-1:0] M_MIN  = CW'(-64'sd2147483648);
    localparam logic signed [SW-1:0] X_MAX  = SW'(64'sd2147483647);
    localparam logic signed [SW-1:0] X_MIN  = SW'(-64'sd2147483648);

    // filter state, cleared at reset
    logic signed [31:0] est_reg;
    logic signed [31:0] est_next;
    logic [31:0]        cov_reg;
    logic [31:0]        cov_next;

    // per-item working registers
    logic signed [15:0]    meas_reg;
    logic [31:0]           pmid_reg;
    logic [32:0]           den_reg;
    logic [33:0]           rem_reg;
    logic [GW-1:0]         gain_reg;
    logic signed [PW-1:0]  prod_reg;
    logic signed [31:0]    xnew_reg;
    logic signed [31:0]    estimate_reg;

    logic [32:0]           pred_sum;
    logic [31:0]           pmid_sat;
    logic                  div_ge;
    logic [33:0]           div_base;
    logic signed [CW-1:0]  m_wide;
    logic signed [31:0]    m_sat;
    logic signed [33:0]    diff;
    logic signed [33:0]    op_a;
    logic signed [GW:0]    op_b;
    logic signed [PW-1:0]  prod;
    logic signed [SW-1:0]  x_sum;
    logic signed [31:0]    x_sat;

    // predicted covariance, saturating
    assign pred_sum = {1'b0, cov_reg} + {1'b0, process_noise};
    assign pmid_sat = pred_sum[32] ? '1 : pred_sum[31:0];

    // restoring divider step, zero divisor gives zero gain
    assign div_ge   = (den_reg != '0) && (rem_reg >= {1'b0, den_reg});
    assign div_base = div_ge ? (rem_reg - {1'b0, den_reg}) : rem_reg;

    // scaled measurement, saturated to 32 bits
    always_comb
    begin
        m_wide = CW'(meas_reg) <<< FRAC_BITS;
        if (m_wide > M_MAX)
        begin
            m_sat = 32'sh7FFF_FFFF;
        end
        else if (m_wide < M_MIN)
        begin
            m_sat = 32'sh8000_0000;
        end
        else
        begin
            m_sat = m_wide[31:0];
        end
    end

    assign diff = 34'(m_sat) - 34'(est_reg);

    // shared multiplier: innovation times gain, then covariance times (1 - gain)
    always_comb
    begin
        if (cmd.mul_x)
        begin
            op_a = diff;
            op_b = $signed({1'b0, gain_reg});
        end
        else
        begin
            op_a = $signed({2'b00, pmid_reg});
            op_b = $signed({1'b0, ONE - gain_reg});
        end
    end

    assign prod = op_a * op_b;

    // estimate update, arithmetic shift rounds toward minus infinity
    always_comb
    begin
        x_sum = SW'(est_reg) + SW'(prod_reg >>> FRAC_BITS);
        if (x_sum > X_MAX)
        begin
            x_sat = 32'sh7FFF_FFFF;
        end
        else if (x_sum < X_MIN)
        begin
            x_sat = 32'sh8000_0000;
        end
        else
        begin
            x_sat = x_sum[31:0];
        end
    end

    // state update on commit
    always_comb
    begin
        est_next = est_reg;
        cov_next = cov_reg;
        if (cmd.commit)
        begin
            est_next = xnew_reg;
            cov_next = prod_reg[FRAC_BITS +: 32];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            est_reg <= '0;
            cov_reg <= '0;
        end
        else
        begin
            est_reg <= est_next;
            cov_reg <= cov_next;
        end
    end

    // working registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            meas_reg <= measurement;
        end
        if (cmd.pred)
        begin
            pmid_reg <= pmid_sat;
        end
        if (cmd.div_init)
        begin
            den_reg  <= {1'b0, pmid_reg} + {1'b0, measure_noise};
            rem_reg  <= {2'b00, pmid_reg};
            gain_reg <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg  <= {div_base[32:0], 1'b0};
            gain_reg <= {gain_reg[GW-2:0], div_ge};
        end
        if (cmd.mul_x || cmd.mul_p)
        begin
            prod_reg <= prod;
        end
        if (cmd.mul_p)
        begin
            xnew_reg <= x_sat;
        end
        if (cmd.commit)
        begin
            estimate_reg <= xnew_reg;
        end
    end

    assign estimate = estimate_reg;

endmodule

>>> hw/rtl/scalar_kalman_filter_unit.sv
// Channel  | Dir | Payload                          | Handshake
// ---------+-----+----------------------------------+--------------------------
// in_ch    | in  | measurement, s16 integer         | valid/ready
// out_ch   | out | estimate, s32 Q(32-F).F          | valid/ready
// APB      | in  | process_noise @0, measure_noise @4 | psel/penable, pready=1
//
// One item at a time: in_ready is low from accept through predict, divide,
// multiply and finish; the gain divider makes one quotient bit a cycle.
// A finished estimate waits in the output register while the next item is taken;
// the last step stalls only if that register is still full.
// Reset (rst_n low, async) clears estimate, covariance and the noise registers
// to their defaults.
module scalar_kalman_filter_unit #(
    parameter int FRAC_BITS = skf_pkg::FRAC_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    skf_meas_if.sink                    in_ch,
    skf_est_if.source                   out_ch,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [skf_pkg::ADDR_W-1:0]  paddr,
    input  logic [skf_pkg::DATA_W-1:0]  pwdata,
    output logic [skf_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);

    skf_pkg::skf_cmd_t cmd;
    logic [31:0]       process_noise;
    logic [31:0]       measure_noise;
    logic              in_ready;
    logic              out_valid;
    logic signed [31:0] estimate;

    // configuration registers
    skf_regs u_regs (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .process_noise (process_noise),
        .measure_noise (measure_noise)
    );

    // sequencer
    skf_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd)
    );

    // arithmetic
    skf_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .measurement   (in_ch.measurement),
        .process_noise (process_noise),
        .measure_noise (measure_noise),
        .estimate      (estimate)
    );

    assign in_ch.ready     = in_ready;
    assign out_ch.valid    = out_valid;
    assign out_ch.estimate = estimate;

endmodule

>>> hw/rtl/skf_checker.sv
module skf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] out_estimate
);

    // one item at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted while an item is in flight");

    // a new result only shows up while an item was being worked on
    a_result_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result without an item in flight");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_estimate)))
        else $error("stalled estimate changed or dropped");

    // nothing comes out while in reset
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("output valid during reset");

endmodule

bind scalar_kalman_filter_unit skf_checker u_skf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_estimate (out_ch.estimate)
);
